[rtl/assert_macros.svh]
// Assertion macros used by the assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, quiet while reset is asserted.
`define GSSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define GSSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gssc_pkg.sv]
`timescale 1ns / 1ps

package gssc_pkg;

  // Field widths
  localparam int ANGLE_W    = 13;
  localparam int SUM_W      = ANGLE_W + 1;
  localparam int TORQUE_W   = 10;
  localparam int COUNT_W    = 6;
  localparam int LOAD_W     = 12;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Angles are in 1/2^ANGLE_FRAC_BITS degree; one step is one degree
  localparam int ANGLE_FRAC_BITS = 4;
  localparam logic signed [SUM_W-1:0] STEP_UNITS = SUM_W'(1 << ANGLE_FRAC_BITS);

  localparam logic [TORQUE_W-1:0] TORQUE_MAX = TORQUE_W'(1023);

  // floor(x / 5) as (x * 13108) >> 16, exact for x below 16384
  localparam int DIV5_SHIFT = 16;
  localparam int DIV5_PROD_W = 27;
  localparam logic [DIV5_PROD_W-1:0] DIV5_RECIP = DIV5_PROD_W'(13108);

  // Load word: magnitude, closing flag, invalid flag
  localparam int LOAD_CLOSING_BIT = 10;
  localparam int LOAD_INVALID_BIT = 11;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] CLOSE_END_RST = ANGLE_W'(320);
  localparam logic signed [ANGLE_W-1:0] OPEN_END_RST  = -ANGLE_W'(1440);
  localparam logic [TORQUE_W-1:0] TORQUE_RES_RST   = TORQUE_W'(1);
  localparam logic [COUNT_W-1:0]  HOLD_COUNT_RST   = COUNT_W'(50);
  localparam logic [TORQUE_W-1:0] DEFAULT_WORD_RST = TORQUE_W'(1023);
  localparam logic [TORQUE_W-1:0] TORQUE_LEVEL_RST = TORQUE_W'(256);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSE_END     = 3'd0,
    REG_OPEN_END      = 3'd1,
    REG_TORQUE_RES    = 3'd2,
    REG_HOLD_COUNT    = 3'd3,
    REG_DEFAULT_WORD  = 3'd4,
    REG_SERVO_ENABLE  = 3'd5
  } reg_idx_t;

  // Commands; unused codes act as a tick
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_MOVE_TO    = 3'd1,
    CMD_MOVE_BY    = 3'd2,
    CMD_SET_TORQUE = 3'd3,
    CMD_SQUEEZE    = 3'd4,
    CMD_SPREAD     = 3'd5
  } cmd_t;

  // Run mode
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_SQUEEZE = 3'b010,
    MODE_SPREAD  = 3'b100
  } mode_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] close_end;
    logic signed [ANGLE_W-1:0] open_end;
    logic [TORQUE_W-1:0]       torque_resolution;
    logic [COUNT_W-1:0]        hold_count;
    logic [TORQUE_W-1:0]       default_torque_word;
    logic                      servo_enable;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [ANGLE_W-1:0] angle_value;
    logic [TORQUE_W-1:0]       torque_value;
    logic                      with_torque;
    logic [LOAD_W-1:0]         load_raw;
  } item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] position_out;
    logic [TORQUE_W-1:0]       torque_word;
    logic                      busy_res;
    logic                      finished;
  } result_t;

  typedef struct packed {
    logic [TORQUE_W-1:0] level;
    logic                changed;
  } tq_t;

  // Limit an angle to the span between the two ends, in either orientation
  function automatic logic signed [ANGLE_W-1:0] clamp_angle(
    input logic signed [SUM_W-1:0]   p,
    input logic signed [ANGLE_W-1:0] closed,
    input logic signed [ANGLE_W-1:0] open
  );
    logic signed [SUM_W-1:0] r;
    r = p;
    if (closed > open) begin
      if (p > closed) r = SUM_W'(closed);
      else if (p < open) r = SUM_W'(open);
    end else begin
      if (p < closed) r = SUM_W'(closed);
      else if (p > open) r = SUM_W'(open);
    end
    return r[ANGLE_W-1:0];
  endfunction

  // Drive torque during a run: min(1023, floor(req * 6 / 5))
  function automatic logic [TORQUE_W-1:0] drive_torque(input logic [TORQUE_W-1:0] req);
    logic [TORQUE_W+2:0]     prod6;
    logic [DIV5_PROD_W-1:0]  scaled;
    logic [TORQUE_W:0]       quot;
    prod6  = (TORQUE_W+3)'(req) * (TORQUE_W+3)'(6);
    scaled = DIV5_PROD_W'(prod6) * DIV5_RECIP;
    quot   = scaled[DIV5_SHIFT +: TORQUE_W+1];
    return (quot > (TORQUE_W+1)'(TORQUE_MAX)) ? TORQUE_MAX : quot[TORQUE_W-1:0];
  endfunction

  // Take a new torque only if it differs from the level by more than the resolution
  function automatic tq_t set_torque(
    input tq_t                 cur,
    input logic [TORQUE_W-1:0] t,
    input logic [TORQUE_W-1:0] res
  );
    logic [TORQUE_W:0] diff;
    tq_t               r;
    r    = cur;
    diff = (cur.level >= t) ? (TORQUE_W+1)'(cur.level - t) : (TORQUE_W+1)'(t - cur.level);
    if (diff > (TORQUE_W+1)'(res)) begin
      r.level   = t;
      r.changed = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/gripper_squeeze_spread_control.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    command, angle, torque, with_torque, load
// out_      output     out_valid/out_ready  position, torque word, busy, finished
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One word per cycle while the output is not stalled; a word passes from input to output
// through the input register, then the result register, the step logic sits between them.
// Reset is synchronous, active low; it empties both registers and loads the
// register defaults. A stalled output holds its word; the input register keeps
// taking words as long as the result register can drain.

module gripper_squeeze_spread_control (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gssc_pkg::CMD_W-1:0]           in_command,
  input  logic signed [gssc_pkg::ANGLE_W-1:0]  in_angle_value,
  input  logic [gssc_pkg::TORQUE_W-1:0]        in_torque_value,
  input  logic                                 in_with_torque,
  input  logic [gssc_pkg::LOAD_W-1:0]          in_load_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gssc_pkg::ANGLE_W-1:0]  out_position_out,
  output logic [gssc_pkg::TORQUE_W-1:0]        out_torque_word,
  output logic                                 out_busy_res,
  output logic                                 out_finished,
  input  logic                                 cfg_we,
  input  logic [gssc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gssc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gssc_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t out_res_r;
  logic    out_vld_r, out_vld_nxt;
  logic    in_fire;
  logic    adv;

  gssc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gssc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (res)
  );

  // Move a word on when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_fire) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (adv) out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.command      <= in_command;
      in_item_r.angle_value  <= in_angle_value;
      in_item_r.torque_value <= in_torque_value;
      in_item_r.with_torque  <= in_with_torque;
      in_item_r.load_raw     <= in_load_raw;
    end
    if (adv) out_res_r <= res;
  end

  assign out_valid        = out_vld_r;
  assign out_position_out = out_res_r.position_out;
  assign out_torque_word  = out_res_r.torque_word;
  assign out_busy_res     = out_res_r.busy_res;
  assign out_finished     = out_res_r.finished;

endmodule

[rtl/gssc_cfg.sv]
`timescale 1ns / 1ps

module gssc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gssc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gssc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output gssc_pkg::cfg_t                     cfg
);
  import gssc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and update one field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CLOSE_END:    cfg_nxt.close_end           = cfg_wdata[ANGLE_W-1:0];
        REG_OPEN_END:     cfg_nxt.open_end            = cfg_wdata[ANGLE_W-1:0];
        REG_TORQUE_RES:   cfg_nxt.torque_resolution   = cfg_wdata[TORQUE_W-1:0];
        REG_HOLD_COUNT:   cfg_nxt.hold_count          = cfg_wdata[COUNT_W-1:0];
        REG_DEFAULT_WORD: cfg_nxt.default_torque_word = cfg_wdata[TORQUE_W-1:0];
        REG_SERVO_ENABLE: cfg_nxt.servo_enable        = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.close_end           <= CLOSE_END_RST;
      cfg_r.open_end            <= OPEN_END_RST;
      cfg_r.torque_resolution   <= TORQUE_RES_RST;
      cfg_r.hold_count          <= HOLD_COUNT_RST;
      cfg_r.default_torque_word <= DEFAULT_WORD_RST;
      cfg_r.servo_enable        <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/gssc_core.sv]
`timescale 1ns / 1ps

module gssc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  gssc_pkg::item_t   item,
  input  gssc_pkg::cfg_t    cfg,
  output gssc_pkg::result_t result
);
  import gssc_pkg::*;

  logic signed [ANGLE_W-1:0] pos_r, pos_nxt;
  logic [TORQUE_W-1:0]       lvl_r, lvl_nxt;
  logic                      chg_r, chg_nxt;
  mode_t                     mode_r, mode_nxt;
  logic [COUNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [ANGLE_W-1:0] foa_r, foa_nxt;
  logic [TORQUE_W-1:0]       req_r, req_nxt;

  tq_t                       tq_v;
  logic                      check_v;
  logic                      over_v;
  logic                      go_v;
  logic                      fin_v;
  logic signed [SUM_W-1:0]   step_v;
  logic signed [SUM_W-1:0]   back_v;
  logic [TORQUE_W-1:0]       mag_v;

  assign mag_v = item.load_raw[TORQUE_W-1:0];

  // One item: command, run step, run end check, then the result word
  always_comb begin
    pos_nxt = pos_r;
    tq_v    = '{level: lvl_r, changed: chg_r};
    mode_nxt = mode_r;
    cnt_nxt = cnt_r;
    foa_nxt = foa_r;
    req_nxt = req_r;
    check_v = 1'b0;
    over_v  = 1'b0;
    go_v    = 1'b1;
    fin_v   = 1'b0;
    step_v  = (mode_r == MODE_SQUEEZE) ? STEP_UNITS : -STEP_UNITS;

    // Any real command cancels a run without finishing it
    if (item.command inside {CMD_MOVE_TO, CMD_MOVE_BY, CMD_SET_TORQUE,
                             CMD_SQUEEZE, CMD_SPREAD}) begin
      mode_nxt = MODE_IDLE;
      cnt_nxt  = '0;
    end

    case (item.command)
      CMD_MOVE_TO: begin
        if (item.with_torque) tq_v = set_torque(tq_v, item.torque_value, cfg.torque_resolution);
        pos_nxt = clamp_angle(SUM_W'(item.angle_value), cfg.close_end, cfg.open_end);
      end
      CMD_MOVE_BY: begin
        if (item.with_torque) tq_v = set_torque(tq_v, item.torque_value, cfg.torque_resolution);
        pos_nxt = clamp_angle(SUM_W'(pos_r) + SUM_W'(item.angle_value),
                              cfg.close_end, cfg.open_end);
      end
      CMD_SET_TORQUE: begin
        tq_v    = set_torque(tq_v, item.torque_value, cfg.torque_resolution);
        pos_nxt = clamp_angle(SUM_W'(pos_r), cfg.close_end, cfg.open_end);
      end
      CMD_SQUEEZE, CMD_SPREAD: begin
        req_nxt  = item.torque_value;
        mode_nxt = (item.command == CMD_SQUEEZE) ? MODE_SQUEEZE : MODE_SPREAD;
        check_v  = 1'b1;
      end
      default: begin
        // Tick: step one degree at drive torque, then sample the load
        if (mode_r != MODE_IDLE) begin
          pos_nxt = clamp_angle(SUM_W'(pos_r) + step_v, cfg.close_end, cfg.open_end);
          tq_v    = set_torque(tq_v, drive_torque(req_r), cfg.torque_resolution);
          if (mode_r == MODE_SQUEEZE) begin
            over_v = !item.load_raw[LOAD_INVALID_BIT] && item.load_raw[LOAD_CLOSING_BIT]
                     && (mag_v > req_r);
          end else begin
            over_v = item.load_raw[LOAD_INVALID_BIT]
                     || (!item.load_raw[LOAD_CLOSING_BIT] && (mag_v > req_r));
          end
          if (over_v) begin
            if (cnt_r == '0) foa_nxt = pos_nxt;
            cnt_nxt = cnt_r + COUNT_W'(1);
          end else begin
            cnt_nxt = '0;
          end
          check_v = 1'b1;
        end
      end
    endcase

    // Decide whether the run goes on
    if (cnt_nxt >= cfg.hold_count) go_v = 1'b0;
    else if (mode_nxt == MODE_SQUEEZE) go_v = (pos_nxt < cfg.close_end);
    else go_v = (pos_nxt > cfg.open_end);

    // End the run: step one degree on past the first over angle, restore requested torque
    back_v = (mode_nxt == MODE_SQUEEZE) ? STEP_UNITS : -STEP_UNITS;
    if (check_v && !go_v) begin
      if (cnt_nxt != '0) begin
        pos_nxt = clamp_angle(SUM_W'(foa_nxt) + back_v, cfg.close_end, cfg.open_end);
      end else begin
        pos_nxt = clamp_angle(SUM_W'(pos_nxt), cfg.close_end, cfg.open_end);
      end
      tq_v     = set_torque(tq_v, req_nxt, cfg.torque_resolution);
      mode_nxt = MODE_IDLE;
      cnt_nxt  = '0;
      fin_v    = 1'b1;
    end

    lvl_nxt = tq_v.level;
    result.busy_res = (mode_nxt != MODE_IDLE);
    result.finished = fin_v;
    if (cfg.servo_enable) begin
      result.position_out = pos_nxt;
      result.torque_word  = tq_v.changed ? tq_v.level : cfg.default_torque_word;
      chg_nxt             = 1'b0;
    end else begin
      result.position_out = '0;
      result.torque_word  = '0;
      chg_nxt             = tq_v.changed;
    end
  end

  // Advance the state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lvl_r  <= TORQUE_LEVEL_RST;
      chg_r  <= 1'b0;
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      foa_r  <= '0;
      req_r  <= '0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      lvl_r  <= lvl_nxt;
      chg_r  <= chg_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      foa_r  <= foa_nxt;
      req_r  <= req_nxt;
    end
  end

endmodule

[rtl/gssc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gssc_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [gssc_pkg::ANGLE_W-1:0]  out_position_out,
  input  logic [gssc_pkg::TORQUE_W-1:0]        out_torque_word,
  input  logic                                 out_busy_res,
  input  logic                                 out_finished
);

  logic [1:0] occ_r, occ_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       out_stall;
  logic       out_both;
  logic [gssc_pkg::ANGLE_W+gssc_pkg::TORQUE_W+1:0] out_word;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_both  = out_finished && out_busy_res;
  assign out_word  = {out_position_out, out_torque_word, out_busy_res, out_finished};

  // Track words taken in and not yet delivered
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) occ_nxt = occ_r + 2'd1;
    else if (!in_acc && out_acc) occ_nxt = occ_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= 2'd0;
    else occ_r <= occ_nxt;
  end

  `GSSC_ASSERT(a_fin_not_busy, clk, rst_n, out_valid |-> !out_both, "finished word shows busy")
  `GSSC_ASSERT(a_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word), "stall broken")
  `GSSC_ASSERT(a_no_invented, clk, rst_n, out_valid |-> occ_r != 2'd0, "word from nowhere")
  `GSSC_ASSERT(a_depth, clk, rst_n, occ_r != 2'd3, "more than two words in flight")
  `GSSC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind gripper_squeeze_spread_control gssc_checker u_gssc_checker (.*);

[sim/gssc_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels, predicts every result word and
// compares it with what the controller returns.
module gssc_scoreboard
  import gssc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [CMD_W-1:0]            in_command,
  input  logic signed [ANGLE_W-1:0]   in_angle_value,
  input  logic [TORQUE_W-1:0]         in_torque_value,
  input  logic                        in_with_torque,
  input  logic [LOAD_W-1:0]           in_load_raw,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [ANGLE_W-1:0]   out_position_out,
  input  logic [TORQUE_W-1:0]         out_torque_word,
  input  logic                        out_busy_res,
  input  logic                        out_finished,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  output int                          mismatches,
  output int                          pending
);

  localparam int DEG = 1 << ANGLE_FRAC_BITS;

  // Register copies
  logic signed [ANGLE_W-1:0] closed_q;
  logic signed [ANGLE_W-1:0] open_q;
  logic [TORQUE_W-1:0]       res_q;
  logic [COUNT_W-1:0]        hold_q;
  logic [TORQUE_W-1:0]       idle_word_q;
  logic                      enable_q;

  // Controller state
  logic signed [ANGLE_W-1:0] angle_q;
  logic [TORQUE_W-1:0]       level_q;
  logic                      torque_fresh;
  mode_t                     mode_q;
  logic [COUNT_W-1:0]        over_run;
  logic signed [ANGLE_W-1:0] first_over;
  logic [TORQUE_W-1:0]       req_torque;

  result_t due_words[$];
  result_t got;
  result_t want;

  // Keep an angle between the two ends, whichever way round they lie
  function automatic logic signed [ANGLE_W-1:0] limit_angle(int a);
    if (closed_q > open_q) begin
      if (a > closed_q) a = closed_q;
      else if (a < open_q) a = open_q;
    end else begin
      if (a < closed_q) a = closed_q;
      else if (a > open_q) a = open_q;
    end
    return ANGLE_W'(a);
  endfunction

  // Take a torque only when it differs by more than the resolution
  function automatic void take_torque(logic [TORQUE_W-1:0] t);
    int diff;
    diff = int'(level_q) - int'(t);
    if (diff < 0) diff = -diff;
    if (diff > int'(res_q)) begin
      level_q      = t;
      torque_fresh = 1'b1;
    end
  endfunction

  function automatic bit run_goes_on();
    if (over_run >= hold_q) return 1'b0;
    if (mode_q == MODE_SQUEEZE) return angle_q < closed_q;
    return angle_q > open_q;
  endfunction

  // Step one degree on past the first over-load angle, restore the requested torque
  function automatic void end_run();
    int target;
    target = int'(angle_q);
    if (over_run != '0) begin
      if (mode_q == MODE_SQUEEZE) target = int'(first_over) + DEG;
      else target = int'(first_over) - DEG;
    end
    angle_q = limit_angle(target);
    take_torque(req_torque);
    mode_q   = MODE_IDLE;
    over_run = '0;
  endfunction

  // One degree step with boosted torque, then sample the load
  function automatic void step_run(logic [LOAD_W-1:0] load);
    int                  drive;
    bit                  squeeze;
    bit                  ok;
    bit                  closing;
    bit                  over;
    logic [TORQUE_W-1:0] mag;
    squeeze = (mode_q == MODE_SQUEEZE);
    drive   = int'(req_torque) * 6 / 5;
    if (drive > int'(TORQUE_MAX)) drive = int'(TORQUE_MAX);
    ok      = !load[LOAD_INVALID_BIT];
    closing = load[LOAD_CLOSING_BIT];
    mag     = load[TORQUE_W-1:0];
    take_torque(TORQUE_W'(drive));
    angle_q = limit_angle(int'(angle_q) + (squeeze ? DEG : -DEG));
    if (squeeze) over = ok && closing && (mag > req_torque);
    else over = !ok || (!closing && (mag > req_torque));
    if (over) begin
      if (over_run == '0) first_over = angle_q;
      over_run = over_run + 1'b1;
    end else begin
      over_run = '0;
    end
  endfunction

  // Advance the controller by one command word and form its result word
  function automatic result_t servo_response(
    logic [CMD_W-1:0]          cmd,
    logic signed [ANGLE_W-1:0] ang,
    logic [TORQUE_W-1:0]       tq,
    logic                      wt,
    logic [LOAD_W-1:0]         load
  );
    result_t r;
    bit      done;
    done = 1'b0;
    case (cmd)
      CMD_MOVE_TO, CMD_MOVE_BY, CMD_SET_TORQUE, CMD_SQUEEZE, CMD_SPREAD: begin
        mode_q   = MODE_IDLE;
        over_run = '0;
      end
      default: ;
    endcase
    case (cmd)
      CMD_MOVE_TO: begin
        if (wt) take_torque(tq);
        angle_q = limit_angle(int'(ang));
      end
      CMD_MOVE_BY: begin
        if (wt) take_torque(tq);
        angle_q = limit_angle(int'(angle_q) + int'(ang));
      end
      CMD_SET_TORQUE: begin
        take_torque(tq);
        angle_q = limit_angle(int'(angle_q));
      end
      CMD_SQUEEZE, CMD_SPREAD: begin
        req_torque = tq;
        if (cmd == CMD_SQUEEZE) mode_q = MODE_SQUEEZE;
        else mode_q = MODE_SPREAD;
        if (!run_goes_on()) begin
          end_run();
          done = 1'b1;
        end
      end
      default: begin
        // tick and spare codes: step only while a run is active
        if (mode_q != MODE_IDLE) begin
          step_run(load);
          if (!run_goes_on()) begin
            end_run();
            done = 1'b1;
          end
        end
      end
    endcase
    if (enable_q) begin
      r.position_out = angle_q;
      r.torque_word  = torque_fresh ? level_q : idle_word_q;
      torque_fresh   = 1'b0;
    end else begin
      r.position_out = '0;
      r.torque_word  = '0;
    end
    r.busy_res = (mode_q != MODE_IDLE);
    r.finished = done;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      closed_q     = CLOSE_END_RST;
      open_q       = OPEN_END_RST;
      res_q        = TORQUE_RES_RST;
      hold_q       = HOLD_COUNT_RST;
      idle_word_q  = DEFAULT_WORD_RST;
      enable_q     = 1'b1;
      angle_q      = '0;
      level_q      = TORQUE_LEVEL_RST;
      torque_fresh = 1'b0;
      mode_q       = MODE_IDLE;
      over_run     = '0;
      first_over   = '0;
      req_torque   = '0;
      due_words.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOSE_END:    closed_q    = cfg_wdata[ANGLE_W-1:0];
          REG_OPEN_END:     open_q      = cfg_wdata[ANGLE_W-1:0];
          REG_TORQUE_RES:   res_q       = cfg_wdata[TORQUE_W-1:0];
          REG_HOLD_COUNT:   hold_q      = cfg_wdata[COUNT_W-1:0];
          REG_DEFAULT_WORD: idle_word_q = cfg_wdata[TORQUE_W-1:0];
          REG_SERVO_ENABLE: enable_q    = cfg_wdata[0];
          default: ;
        endcase
      end

      // Predict on every accepted command word
      if (in_valid && in_ready) begin
        due_words.push_back(servo_response(in_command, in_angle_value, in_torque_value,
                                           in_with_torque, in_load_raw));
      end

      // Compare every accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        got.position_out = out_position_out;
        got.torque_word  = out_torque_word;
        got.busy_res     = out_busy_res;
        got.finished     = out_finished;
        if (due_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with no command pending: position %0d torque %0d",
                     $realtime, $signed(got.position_out), got.torque_word);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (got.position_out !== want.position_out || got.torque_word !== want.torque_word ||
              got.busy_res !== want.busy_res || got.finished !== want.finished) begin
            if (mismatches < 10)
              $display("%0t: mismatch (expected/actual) position %0d/%0d torque %0d/%0d %s",
                       $realtime, $signed(want.position_out), $signed(got.position_out),
                       want.torque_word, got.torque_word,
                       $sformatf("busy %0b/%0b finished %0b/%0b", want.busy_res,
                                 got.busy_res, want.finished, got.finished));
            mismatches++;
          end
        end
      end
    end
    pending = due_words.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import gssc_pkg::*;

  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 112;
  localparam int CYCLE_LIMIT     = 200000;

  // Unused command codes, which the controller treats as a tick
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_command      = '0;
  logic signed [ANGLE_W-1:0] in_angle_value  = '0;
  logic [TORQUE_W-1:0]       in_torque_value = '0;
  logic                      in_with_torque  = 1'b0;
  logic [LOAD_W-1:0]         in_load_raw     = '0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic signed [ANGLE_W-1:0] out_position_out;
  logic [TORQUE_W-1:0]       out_torque_word;
  logic                      out_busy_res;
  logic                      out_finished;
  logic                      cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index       = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata       = '0;

  int          mismatches;
  int          pending;
  int unsigned cycles     = 0;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;
  int unsigned rx_wait;
  bit          no_gaps    = 1'b0;
  bit          no_stalls  = 1'b0;

  gripper_squeeze_spread_control dut (.*);

  gssc_scoreboard u_scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: after each taken word, drop ready for a random stall unless no_stalls is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      rx_wait = no_stalls ? 0 : $urandom_range(0, 3);
      stall_left <= rx_wait;
      out_ready  <= (rx_wait == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Idle for a random gap unless no_gaps is set, present one command word and hold it until taken
  task automatic send_word(
    logic [CMD_W-1:0]          cmd,
    logic signed [ANGLE_W-1:0] ang,
    logic [TORQUE_W-1:0]       tq,
    logic                      wt,
    logic [LOAD_W-1:0]         load
  );
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_angle_value  <= ang;
    in_torque_value <= tq;
    in_with_torque  <= wt;
    in_load_raw     <= load;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(
    logic signed [ANGLE_W-1:0] closed,
    logic signed [ANGLE_W-1:0] open,
    logic [TORQUE_W-1:0]       res,
    logic [COUNT_W-1:0]        hold,
    logic [TORQUE_W-1:0]       idle_word,
    logic                      en
  );
    write_reg(REG_CLOSE_END, closed);
    write_reg(REG_OPEN_END, open);
    write_reg(REG_TORQUE_RES, CFG_DATA_W'(res));
    write_reg(REG_HOLD_COUNT, CFG_DATA_W'(hold));
    write_reg(REG_DEFAULT_WORD, CFG_DATA_W'(idle_word));
    write_reg(REG_SERVO_ENABLE, CFG_DATA_W'(en));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly full range, sometimes a small signed step
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 3) == 0) return ANGLE_W'(int'($urandom_range(0, 128)) - 64);
    return ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
  endfunction

  // Load word that counts as over the request for the given run, or any word
  function automatic logic [LOAD_W-1:0] make_load(
    logic [CMD_W-1:0]    run_cmd,
    logic [TORQUE_W-1:0] req,
    bit                  want_over
  );
    logic [LOAD_W-1:0] load;
    if (!want_over) return LOAD_W'($urandom_range(0, (1 << LOAD_W) - 1));
    if (run_cmd == CMD_SPREAD && $urandom_range(0, 3) == 0)
      return LOAD_W'($urandom_range(1 << LOAD_INVALID_BIT, (1 << LOAD_W) - 1));
    load = '0;
    load[TORQUE_W-1:0] = (req == TORQUE_MAX) ? TORQUE_MAX :
                         TORQUE_W'($urandom_range(int'(req) + 1, int'(TORQUE_MAX)));
    load[LOAD_CLOSING_BIT] = (run_cmd == CMD_SQUEEZE);
    return load;
  endfunction

  task automatic send_noise();
    send_word(CMD_W'($urandom_range(CMD_TICK, CMD_SPARE_HI)), pick_angle(),
              TORQUE_W'($urandom_range(0, TORQUE_MAX)), 1'($urandom_range(0, 1)),
              LOAD_W'($urandom_range(0, (1 << LOAD_W) - 1)));
  endtask

  // Start a squeeze or spread and feed it ticks with a chosen share of over-loads
  task automatic send_run();
    logic [CMD_W-1:0]    start;
    logic [CMD_W-1:0]    step_cmd;
    logic [TORQUE_W-1:0] req;
    int unsigned         ticks;
    int unsigned         over_pct;
    start = $urandom_range(0, 1) ? CMD_SQUEEZE : CMD_SPREAD;
    case ($urandom_range(0, 5))
      0:       req = '0;
      1:       req = TORQUE_MAX;
      default: req = TORQUE_W'($urandom_range(0, TORQUE_MAX));
    endcase
    over_pct = $urandom_range(0, 100);
    ticks    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 30);
    send_word(start, pick_angle(), req, 1'($urandom_range(0, 1)),
              LOAD_W'($urandom_range(0, (1 << LOAD_W) - 1)));
    repeat (ticks) begin
      if ($urandom_range(0, 39) == 0) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 9) == 0)
          step_cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        else
          step_cmd = CMD_TICK;
        send_word(step_cmd, pick_angle(), TORQUE_W'($urandom_range(0, TORQUE_MAX)),
                  1'($urandom_range(0, 1)),
                  make_load(start, req, $urandom_range(0, 99) < over_pct));
      end
    end
  endtask

  initial begin
    int                        target;
    logic signed [ANGLE_W-1:0] lo;
    logic signed [ANGLE_W-1:0] hi;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings
    send_word(CMD_TICK, 0, 0, 1'b0, 0);
    send_word(CMD_MOVE_TO, 4095, TORQUE_MAX, 1'b1, 0);
    send_word(CMD_MOVE_TO, -4096, 0, 1'b1, 0);
    send_word(CMD_MOVE_BY, 4095, 0, 1'b0, 0);
    send_word(CMD_MOVE_BY, -4096, 1, 1'b1, 0);
    send_word(CMD_SET_TORQUE, 0, TORQUE_MAX, 1'b0, 0);
    send_word(CMD_SET_TORQUE, 0, TORQUE_MAX - 1, 1'b0, 0);
    send_word(CMD_MOVE_TO, 0, 0, 1'b0, 0);
    send_word(CMD_SQUEEZE, 0, 100, 1'b0, 0);
    send_word(CMD_TICK, 0, 0, 1'b0, 12'h7FF);
    send_word(CMD_TICK, 0, 0, 1'b0, 12'hFFF);
    send_word(CMD_SPARE_LO, 0, 0, 1'b0, 12'h500);
    send_word(CMD_SPARE_HI, 0, 0, 1'b0, 12'h400);
    send_word(CMD_MOVE_BY, 16, 0, 1'b0, 0);
    send_word(CMD_SPREAD, 0, TORQUE_MAX, 1'b0, 0);
    send_word(CMD_TICK, 0, 0, 1'b0, 12'h800);
    send_word(CMD_TICK, 0, 0, 1'b0, 12'h3FF);
    send_word(CMD_SET_TORQUE, 0, 512, 1'b0, 0);
    send_word(CMD_MOVE_TO, 300, 0, 1'b0, 0);
    send_word(CMD_SQUEEZE, 0, 0, 1'b0, 0);
    send_word(CMD_TICK, 0, 0, 1'b0, 12'h401);
    send_word(CMD_TICK, 0, 0, 1'b0, 0);
    send_word(CMD_SPREAD, 0, 1, 1'b0, 0);

    // Random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: load_settings(4095, -4096, 0, 63, 0, 1'b1);
        1: load_settings(-4096, 4095, TORQUE_MAX, 1, TORQUE_MAX, 1'b1);
        2: load_settings(320, -1440, 1, 0, 512, 1'b0);
        3: load_settings(100, 100, 5, 3, 341, 1'b1);
        4: load_settings(-200, 600, 2, 4, 682, 1'b1);
        default: begin
          lo = -ANGLE_W'($urandom_range(0, 2000));
          hi = ANGLE_W'($urandom_range(0, 2000));
          load_settings($urandom_range(0, 4) == 0 ? lo : hi,
                        $urandom_range(0, 4) == 0 ? hi : lo,
                        ($urandom_range(0, 3) == 0) ? TORQUE_W'($urandom_range(0, TORQUE_MAX))
                                                    : TORQUE_W'($urandom_range(0, 8)),
                        ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 63))
                                                    : COUNT_W'($urandom_range(1, 8)),
                        TORQUE_W'($urandom_range(0, TORQUE_MAX)),
                        1'($urandom_range(0, 7) != 0));
        end
      endcase
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        no_gaps   = ($urandom_range(0, 4) == 0);
        no_stalls = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0) begin
          send_run();
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end

    // Drain and give the verdict
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/gssc_pkg.sv
rtl/gssc_cfg.sv
rtl/gssc_core.sv
rtl/gripper_squeeze_spread_control.sv
rtl/gssc_checker.sv
sim/gssc_checker.sv
sim/tb_top.sv
